FILE: rtl/core/pqot_pkg.sv
// Shared constants for the planar quad overlap test pipeline.
// Holds the vertex layout and the edge table. It depends on nothing else.
`timescale 1ns / 1ps
package pqot_pkg;
	localparam int COORD_BITS_DEF = 16;
	localparam int VERTEX_BITS    = 32;
	localparam int NUM_VERTS      = 4;
	localparam int NUM_EDGES      = 5;
	localparam int NUM_CROSS      = NUM_EDGES * NUM_EDGES;
	localparam int MARGIN_BITS    = 32;

	typedef int edge_tab_t [NUM_EDGES];

	// These are the distinct edges of triangles (0,1,2) and (0,2,3). The diagonal
	// appears once, as 2->0.
	localparam edge_tab_t EDGE_A = '{0, 1, 2, 2, 3};
	localparam edge_tab_t EDGE_B = '{1, 2, 0, 3, 0};

	// These are the positions of the edges in EDGE_A/EDGE_B.
	localparam int E01 = 0;
	localparam int E12 = 1;
	localparam int E20 = 2;
	localparam int E23 = 3;
	localparam int E30 = 4;
endpackage

FILE: rtl/core/planar_quad_overlap_test.sv
// Top level of the planar quad overlap test: a six-stage stallable pipeline.
// It depends on pqot_pkg for the vertex layout and the edge table.
//
// channel  | dir | width | contents
// s_axis   | in  | 256   | first quad vertex 0..3, second quad vertex 0..3, 32 bits each
// m_axis   | out | 8     | overlaps in bit 0
// cfg      | in  | 32    | overlap_margin
//
// One request enters each cycle while m_axis_tready does not stall the pipeline; its answer leaves from stage 6.
// The stages are: unpack, differences and products with box test, orientation subtract,
// sign and magnitude flags, 32x32 magnitude products, and final compare.
// Each stage holds its request when the stage after it is full and stalled, so bubbles still fill.
// Reset clears the valid bits and the margin register only.
`timescale 1ns / 1ps
module planar_quad_overlap_test #(
	parameter int COORD_BITS = pqot_pkg::COORD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// Fields from bit 0 up: first_quad_vertex0..3, second_quad_vertex0..3.
	input  logic [255:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// Fields from bit 0 up: overlaps, then zero padding.
	output logic [7:0]   m_axis_tdata,
	input  logic         cfg_wen,
	input  logic [31:0]  cfg_wdata
);
	localparam int VB = pqot_pkg::VERTEX_BITS;
	localparam int NV = pqot_pkg::NUM_VERTS;
	localparam int NE = pqot_pkg::NUM_EDGES;
	localparam int NC = pqot_pkg::NUM_CROSS;
	localparam int MB = pqot_pkg::MARGIN_BITS;
	localparam int UW = 2 * COORD_BITS + VB;
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * COORD_BITS + 2;
	localparam int OW = 2 * COORD_BITS + 3;
	localparam int BW = (COORD_BITS > MB ? COORD_BITS : MB) + 3;
	localparam int XW = (OW > MB ? OW : MB) + 2;

	logic [MB-1:0] margin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= '0;
		end else if (cfg_wen) begin
			margin_q <= cfg_wdata;
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v_s6 || m_axis_tready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// Stage 1: unpack. Bits above the 32-bit word read as zero.
	logic signed [COORD_BITS-1:0] x_s1 [2][NV];
	logic signed [COORD_BITS-1:0] y_s1 [2][NV];

	for (genvar q = 0; q < 2; q++) begin : g_unpack
		for (genvar i = 0; i < NV; i++) begin : g_vert
			logic [UW-1:0] word;
			assign word = UW'(s_axis_tdata[(q * NV + i) * VB +: VB]);
			always_ff @(posedge clk) begin
				if (en1) begin
					x_s1[q][i] <= word[COORD_BITS-1:0];
					y_s1[q][i] <= word[2*COORD_BITS-1:COORD_BITS];
				end
			end
		end
	end

	// Stage 2: the box test and the two products of every orientation.
	logic signed [BW-1:0] mnx [2];
	logic signed [BW-1:0] mxx [2];
	logic signed [BW-1:0] mny [2];
	logic signed [BW-1:0] mxy [2];
	logic signed [BW-1:0] eps_b;
	logic                 box_ok;

	assign eps_b = signed'(BW'(margin_q));

	always_comb begin
		for (int q = 0; q < 2; q++) begin
			mnx[q] = BW'(x_s1[q][0]);
			mxx[q] = BW'(x_s1[q][0]);
			mny[q] = BW'(y_s1[q][0]);
			mxy[q] = BW'(y_s1[q][0]);
			for (int i = 1; i < NV; i++) begin
				if (BW'(x_s1[q][i]) < mnx[q]) mnx[q] = BW'(x_s1[q][i]);
				if (BW'(x_s1[q][i]) > mxx[q]) mxx[q] = BW'(x_s1[q][i]);
				if (BW'(y_s1[q][i]) < mny[q]) mny[q] = BW'(y_s1[q][i]);
				if (BW'(y_s1[q][i]) > mxy[q]) mxy[q] = BW'(y_s1[q][i]);
			end
		end
		box_ok = !((mxx[0] <= mnx[1] + eps_b) || (mxx[1] <= mnx[0] + eps_b) ||
			(mxy[0] <= mny[1] + eps_b) || (mxy[1] <= mny[0] + eps_b));
	end

	logic signed [PW-1:0] p1_s2 [2][NE][NV];
	logic signed [PW-1:0] p2_s2 [2][NE][NV];
	logic signed [OW-1:0] o_s3  [2][NE][NV];
	logic box_s2, box_s3, box_s4, box_s5;

	// o_s3[q][e][v] is the orientation of edge e of quad q against vertex v of the other quad.
	for (genvar q = 0; q < 2; q++) begin : g_orient
		for (genvar e = 0; e < NE; e++) begin : g_edge
			for (genvar v = 0; v < NV; v++) begin : g_vtx
				localparam int SA = pqot_pkg::EDGE_A[e];
				localparam int SB = pqot_pkg::EDGE_B[e];
				logic signed [DW-1:0] dx1, dy1, dx2, dy2;
				assign dx1 = DW'(x_s1[q][SB]) - DW'(x_s1[q][SA]);
				assign dy1 = DW'(y_s1[q][SB]) - DW'(y_s1[q][SA]);
				assign dx2 = DW'(x_s1[1-q][v]) - DW'(x_s1[q][SA]);
				assign dy2 = DW'(y_s1[1-q][v]) - DW'(y_s1[q][SA]);
				always_ff @(posedge clk) begin
					if (en2) begin
						p1_s2[q][e][v] <= PW'(dx1) * PW'(dy2);
						p2_s2[q][e][v] <= PW'(dy1) * PW'(dx2);
					end
					if (en3) begin
						o_s3[q][e][v] <= OW'(p1_s2[q][e][v]) - OW'(p2_s2[q][e][v]);
					end
				end
			end
		end
	end

	// Stage 4: the sign and magnitude flags of each crossing, and the inside tests.
	logic        opp_s4 [2][NC];
	logic        big_s4 [2][NC];
	logic [31:0] ma_s4  [2][NC];
	logic [31:0] mb_s4  [2][NC];
	logic [63:0] prod_s5 [2][NC];
	logic        opp_s5 [2][NC];
	logic        big_s5 [2][NC];

	for (genvar ea = 0; ea < NE; ea++) begin : g_ca
		for (genvar eb = 0; eb < NE; eb++) begin : g_cb
			for (genvar h = 0; h < 2; h++) begin : g_half
				localparam int ME = (h == 0) ? ea : eb;
				localparam int OE = (h == 0) ? eb : ea;
				localparam int C  = ea * NE + eb;
				logic signed [OW-1:0] u, w;
				logic [OW-1:0] mu, mw;
				logic [63:0]   mu64, mw64;
				assign u    = o_s3[h][ME][pqot_pkg::EDGE_A[OE]];
				assign w    = o_s3[h][ME][pqot_pkg::EDGE_B[OE]];
				assign mu   = u[OW-1] ? OW'(-u) : OW'(u);
				assign mw   = w[OW-1] ? OW'(-w) : OW'(w);
				assign mu64 = 64'(mu);
				assign mw64 = 64'(mw);
				always_ff @(posedge clk) begin
					if (en4) begin
						opp_s4[h][C] <= (u != '0) && (w != '0) && (u[OW-1] != w[OW-1]);
						big_s4[h][C] <= (|mu64[63:32]) || (|mw64[63:32]);
						ma_s4[h][C]  <= mu64[31:0];
						mb_s4[h][C]  <= mw64[31:0];
					end
					if (en5) begin
						prod_s5[h][C] <= 64'(ma_s4[h][C]) * 64'(mb_s4[h][C]);
						opp_s5[h][C]  <= opp_s4[h][C];
						big_s5[h][C]  <= big_s4[h][C];
					end
				end
			end
		end
	end

	logic signed [XW-1:0] eps_x;
	logic                 pos [2][NE];
	logic                 neg [2][NE];
	logic                 vtx_in;
	logic                 inside_s4, inside_s5;

	assign eps_x = signed'(XW'(margin_q));

	// Vertex 0 of one quad against both triangles of the other. The diagonal is stored as 2->0,
	// so in triangle (0,2,3) its sign flips.
	always_comb begin
		vtx_in = 1'b0;
		for (int q = 0; q < 2; q++) begin
			for (int e = 0; e < NE; e++) begin
				pos[q][e] = XW'(o_s3[q][e][0]) > eps_x;
				neg[q][e] = XW'(o_s3[q][e][0]) < -eps_x;
			end
			vtx_in = vtx_in ||
				(pos[q][pqot_pkg::E01] && pos[q][pqot_pkg::E12] && pos[q][pqot_pkg::E20]) ||
				(neg[q][pqot_pkg::E01] && neg[q][pqot_pkg::E12] && neg[q][pqot_pkg::E20]) ||
				(neg[q][pqot_pkg::E20] && pos[q][pqot_pkg::E23] && pos[q][pqot_pkg::E30]) ||
				(pos[q][pqot_pkg::E20] && neg[q][pqot_pkg::E23] && neg[q][pqot_pkg::E30]);
		end
	end

	always_ff @(posedge clk) begin
		if (en2) box_s2 <= box_ok;
		if (en3) box_s3 <= box_s2;
		if (en4) begin
			box_s4    <= box_s3;
			inside_s4 <= vtx_in;
		end
		if (en5) begin
			box_s5    <= box_s4;
			inside_s5 <= inside_s4;
		end
	end

	// Stage 6: the final compare against the margin, held in the output register.
	logic [NC-1:0] cross_hit;
	logic          hit_s6;

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			cross_hit[c] = opp_s5[0][c] &&
				(big_s5[0][c] || (prod_s5[0][c] > 64'(margin_q))) &&
				opp_s5[1][c] && (big_s5[1][c] || (prod_s5[1][c] > 64'(margin_q)));
		end
	end

	always_ff @(posedge clk) begin
		if (en6) hit_s6 <= box_s5 && ((|cross_hit) || inside_s5);
	end

	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = {7'b0, hit_s6};
endmodule
